/* hdl/msw_pkg.sv */
package msw_pkg;

    // Default build parameters
    localparam int unsigned SINE_TABLE_BITS_DEF = 10;
    localparam int unsigned PHASE_BITS_DEF      = 32;

    // Field and register widths
    localparam int unsigned AMP_W      = 15;
    localparam int unsigned STEP_MS_W  = 15;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned SINE_W     = 16;

    // Register reset values
    localparam logic [AMP_W-1:0]      AMP_RST        = 15'd10;
    localparam logic [CFG_DATA_W-1:0] PHASE_STEP_RST = 32'd536870912;
    localparam logic [STEP_MS_W-1:0]  STEP_MS_RST    = 15'd125;

    // pi/2 in Q30, rounded
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_COSINE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } t_wave_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_KIND      = 2'd0,
        CFG_AMPLITUDE      = 2'd1,
        CFG_PHASE_STEP     = 2'd2,
        CFG_SAMPLE_STEP_MS = 2'd3
    } t_cfg_index;

    // Quarter-wave sine entry in Q15, built from a Q30 Taylor series
    function automatic logic [SINE_W-1:0] f_sine_entry(input int unsigned idx,
                                                       input int unsigned table_bits);
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        x    = (64'(idx) * HALF_PI_Q30) >> table_bits;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            unique case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                default: term = term;
            endcase
            if ((k % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        return SINE_W'((sum + 16384) >>> 15);
    endfunction

endpackage

/* hdl/multi_shape_waveform_generator_core.sv */
// An accepted request passes through stage 1 (table read), stage 2 (products) and
// the output register; a sawtooth period wrap adds a second result after the first.
// Throughput: one request per cycle while the output is not stalled, set by the
// single-add phase and time update; a wrap's second result also holds the pipeline.
// Reset (synchronous, active low): phase and time clear, registers take their defaults,
// the pipeline empties. The sine table is a constant ROM and needs no fill after reset.
module multi_shape_waveform_generator_core
    import msw_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_restart,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SAMPLE_W-1:0]   o_sample_value,
    output logic [TIME_W-1:0]     o_time_ms,
    output logic                  o_last,
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data
);

    localparam int unsigned TABLE_LEN = (1 << SINE_TABLE_BITS) + 1;
    localparam int unsigned IDX_W     = SINE_TABLE_BITS + 1;
    localparam int unsigned PROD_AP_W = AMP_W + PHASE_BITS;
    localparam int unsigned PROD_AS_W = AMP_W + SINE_W;
    localparam int unsigned TRI_W     = PROD_AP_W + 2;
    localparam int unsigned VAL_W     = AMP_W + 2;

    localparam logic [IDX_W-1:0]      TBL_TOP   = IDX_W'(1) << SINE_TABLE_BITS;
    localparam logic [PHASE_BITS-1:0] QUARTER   = PHASE_BITS'(1) << (PHASE_BITS - 2);
    localparam logic [PHASE_BITS-1:0] QUARTER_3 = PHASE_BITS'(3) << (PHASE_BITS - 2);
    localparam logic [TRI_W-1:0]      TRI_HALF  = TRI_W'(1) << (PHASE_BITS - 1);
    localparam logic [PROD_AS_W-1:0]  SINE_RND  = PROD_AS_W'(16384);

    typedef logic [SINE_W-1:0] t_sine_rom [TABLE_LEN];

    function automatic t_sine_rom f_build_rom();
        t_sine_rom rom;
        for (int i = 0; i < int'(TABLE_LEN); i++) begin
            rom[i] = f_sine_entry(i, SINE_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_rom();

    // configuration registers
    t_wave_kind            r_wave_kind;
    logic [AMP_W-1:0]      r_amplitude;
    logic [PHASE_BITS-1:0] r_phase_step;
    logic [STEP_MS_W-1:0]  r_step_ms;

    // generator state
    logic [PHASE_BITS-1:0] r_phase;
    logic [TIME_W-1:0]     r_elapsed;
    logic                  r_first;

    // stage 1: table read
    logic                  r1_v;
    t_wave_kind            r1_kind;
    logic [AMP_W-1:0]      r1_a;
    logic [PHASE_BITS-1:0] r1_p;
    logic [TIME_W-1:0]     r1_time;
    logic                  r1_wrap;
    logic                  r1_neg;
    logic [SINE_W-1:0]     r1_sine;

    // stage 2: products
    logic                  r2_v;
    t_wave_kind            r2_kind;
    logic [AMP_W-1:0]      r2_a;
    logic [TIME_W-1:0]     r2_time;
    logic                  r2_wrap;
    logic                  r2_neg;
    logic                  r2_rgn_lo;
    logic                  r2_rgn_mid;
    logic [PROD_AP_W-1:0]  r2_prod_ap;
    logic [PROD_AS_W-1:0]  r2_prod_as;

    // output register
    logic                  r_o_valid;
    logic                  r_extra;
    logic [SAMPLE_W-1:0]   r_sample;
    logic [TIME_W-1:0]     r_time_o;
    logic                  r_last;

    logic                  out_load;
    logic                  en2;
    logic                  en1;
    logic                  accept;

    logic [PHASE_BITS-1:0] p_cur;
    logic [TIME_W-1:0]     time_cur;
    logic                  first_cur;
    logic [1:0]            quad;
    logic [SINE_TABLE_BITS-1:0] idx_raw;
    logic [IDX_W-1:0]      idx;

    logic [TRI_W-1:0]      tri_sum;
    logic [VAL_W-1:0]      tri_q;
    logic [VAL_W-1:0]      a_ext;
    logic [VAL_W-1:0]      a_x3;
    logic [PROD_AS_W-1:0]  sine_sum;
    logic [SAMPLE_W-1:0]   sine_m;
    logic [SAMPLE_W-1:0]   a16;
    logic [VAL_W-1:0]      tri_val;
    logic [SAMPLE_W-1:0]   n_sample;

    // flow control: each stage moves when the next one frees up
    assign out_load = !r_o_valid || (!i_stall && !r_extra);
    assign en2      = !r2_v || out_load;
    assign en1      = !r1_v || en2;
    assign accept   = i_valid && en1;
    assign o_stall  = !en1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_kind  <= WAVE_SINE;
            r_amplitude  <= AMP_RST;
            r_phase_step <= PHASE_BITS'(PHASE_STEP_RST);
            r_step_ms    <= STEP_MS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WAVE_KIND:      r_wave_kind  <= t_wave_kind'(i_cfg_wr_data[1:0]);
                CFG_AMPLITUDE:      r_amplitude  <= i_cfg_wr_data[AMP_W-1:0];
                CFG_PHASE_STEP:     r_phase_step <= i_cfg_wr_data[PHASE_BITS-1:0];
                CFG_SAMPLE_STEP_MS: r_step_ms    <= i_cfg_wr_data[STEP_MS_W-1:0];
            endcase
        end
    end

    // phase and time seen by this request, restart applied first
    always_comb begin
        p_cur     = i_restart ? '0 : r_phase;
        time_cur  = i_restart ? '0 : r_elapsed;
        first_cur = i_restart | r_first;
        quad      = p_cur[PHASE_BITS-1 -: 2] + ((r_wave_kind == WAVE_COSINE) ? 2'd1 : 2'd0);
        idx_raw   = p_cur[PHASE_BITS-3 -: SINE_TABLE_BITS];
        idx       = quad[0] ? (TBL_TOP - {1'b0, idx_raw}) : {1'b0, idx_raw};
    end

    // advance phase and time on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_elapsed <= '0;
            r_first   <= 1'b1;
        end else if (accept) begin
            r_phase   <= p_cur + r_phase_step;
            r_elapsed <= time_cur + TIME_W'(r_step_ms);
            r_first   <= 1'b0;
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= i_valid;
        end
    end

    // stage 1 payload and table read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_kind <= r_wave_kind;
            r1_a    <= r_amplitude;
            r1_p    <= p_cur;
            r1_time <= time_cur;
            r1_wrap <= (r_wave_kind == WAVE_SAWTOOTH) && (p_cur == '0) && !first_cur;
            r1_neg  <= quad[1];
            r1_sine <= SINE_ROM[idx];
        end
    end

    // stage 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v;
        end
    end

    // stage 2: multiply amplitude by phase and by table value
    always_ff @(posedge i_clk) begin
        if (en2 && r1_v) begin
            r2_kind    <= r1_kind;
            r2_a       <= r1_a;
            r2_time    <= r1_time;
            r2_wrap    <= r1_wrap;
            r2_neg     <= r1_neg;
            r2_rgn_lo  <= (r1_p <= QUARTER);
            r2_rgn_mid <= (r1_p <= QUARTER_3);
            r2_prod_ap <= PROD_AP_W'(r1_a) * PROD_AP_W'(r1_p);
            r2_prod_as <= PROD_AS_W'(r1_a) * PROD_AS_W'(r1_sine);
        end
    end

    // shape the sample from the products
    always_comb begin
        tri_sum  = {r2_prod_ap, 2'b00} + TRI_HALF;
        tri_q    = tri_sum[TRI_W-1 -: VAL_W];
        a_ext    = VAL_W'(r2_a);
        a_x3     = {a_ext[VAL_W-2:0], 1'b0} + a_ext;
        sine_sum = r2_prod_as + SINE_RND;
        sine_m   = sine_sum[PROD_AS_W-1 -: SAMPLE_W];
        a16      = SAMPLE_W'(r2_a);
        if (r2_rgn_lo) begin
            tri_val = a_ext + tri_q;
        end else if (r2_rgn_mid) begin
            tri_val = a_x3 - tri_q;
        end else begin
            tri_val = tri_q - a_x3;
        end
        unique case (r2_kind)
            WAVE_SINE, WAVE_COSINE: n_sample = r2_neg ? (a16 - sine_m) : (a16 + sine_m);
            WAVE_TRIANGLE:          n_sample = tri_val[SAMPLE_W-1:0];
            WAVE_SAWTOOTH: begin
                if (r2_wrap) begin
                    n_sample = {r2_a, 1'b0};
                end else begin
                    n_sample = r2_prod_ap[PHASE_BITS-1 +: SAMPLE_W];
                end
            end
        endcase
    end

    // output control: hold, then drop or follow with the wrap's zero sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_extra   <= 1'b0;
        end else if (r_o_valid && !i_stall && r_extra) begin
            r_extra   <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= r2_v;
            r_extra   <= r2_v && r2_wrap;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_o_valid && !i_stall && r_extra) begin
            r_sample <= '0;
            r_last   <= 1'b1;
        end else if (out_load && r2_v) begin
            r_sample <= n_sample;
            r_time_o <= r2_time;
            r_last   <= !r2_wrap;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_sample_value = r_sample;
    assign o_time_ms      = r_time_o;
    assign o_last         = r_last;

`ifndef SYNTH
    // the first result of a wrap is always followed by a zero final result
    a_wrap_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last && !i_stall) |=> (o_valid && o_last && (o_sample_value == '0)))
        else $error("wrap result not followed by zero final sample");

    // a restart request enters the pipeline with time zero
    a_restart_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_restart) |=> (r1_v && (r1_time == '0)))
        else $error("restart did not clear time");

    // a full stage 1 that cannot move must block new requests
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_v && r2_v && !out_load) |-> o_stall)
        else $error("request accepted over a held stage");

    // a pending zero sample only exists behind a valid output
    a_extra_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_extra |-> (r_o_valid && !r_last))
        else $error("pending wrap sample without valid output");
`endif

endmodule
